// ----- design/cpb_pkg.sv -----
package cpb_pkg;

  localparam int MAX_LEVELS = 8;
  localparam int DIGIT_W    = 16;
  localparam int ACTOR_W    = 32;
  localparam int LEVEL_W    = 3;
  localparam int CNT_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  localparam logic [DIGIT_W-1:0] DIGIT_TOP = 16'hFFFF;

  typedef logic [CNT_W-1:0] lvl_cnt_t;

  typedef struct packed {
    logic               start_req;
    logic               left_present;
    logic [DIGIT_W-1:0] left_digit;
    logic [ACTOR_W-1:0] left_actor;
    logic               right_present;
    logic [DIGIT_W-1:0] right_digit;
    logic [ACTOR_W-1:0] new_actor;
  } in_item_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] out_digit;
    logic [ACTOR_W-1:0] out_actor;
    logic [LEVEL_W-1:0] level;
    logic               is_last;
  } out_item_t;

  // low bits of the level counter, zero extended when the counter is narrow
  function automatic logic [LEVEL_W-1:0] to_level(lvl_cnt_t c);
    logic [CNT_W+LEVEL_W-1:0] w;
    w = {{LEVEL_W{1'b0}}, c};
    return w[LEVEL_W-1:0];
  endfunction

endpackage

// ----- design/cpb_if.sv -----
interface cpb_in_if;
  import cpb_pkg::*;
  logic               valid;
  logic               ready;
  logic               start_req;
  logic               left_present;
  logic [DIGIT_W-1:0] left_digit;
  logic [ACTOR_W-1:0] left_actor;
  logic               right_present;
  logic [DIGIT_W-1:0] right_digit;
  logic [ACTOR_W-1:0] new_actor;

  modport source (output valid, start_req, left_present, left_digit, left_actor,
                  right_present, right_digit, new_actor, input ready);
  modport sink (input valid, start_req, left_present, left_digit, left_actor,
                right_present, right_digit, new_actor, output ready);
endinterface

interface cpb_out_if;
  import cpb_pkg::*;
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] out_digit;
  logic [ACTOR_W-1:0] out_actor;
  logic [LEVEL_W-1:0] level;
  logic               is_last;

  modport source (output valid, out_digit, out_actor, level, is_last, input ready);
  modport sink (input valid, out_digit, out_actor, level, is_last, output ready);
endinterface

// ----- design/cpb_in_reg.sv -----
module cpb_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cpb_pkg::in_item_t in_item,
  input  logic              s1_take,
  output logic              s1_valid,
  output cpb_pkg::in_item_t s1_item
);
  import cpb_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // refill in the same cycle the held item moves on
  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;
endmodule

// ----- design/cpb_alloc.sv -----
module cpb_alloc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  cpb_pkg::in_item_t  s1_item,
  input  logic               slot_free,
  output logic               s1_take,
  output logic               res_load,
  output cpb_pkg::out_item_t res_item
);
  import cpb_pkg::*;

  lvl_cnt_t cnt_r, cnt_nxt;
  logic     fin_r, fin_nxt;

  lvl_cnt_t          cnt_eff;
  logic              fin_eff;
  logic              produce;
  logic [DIGIT_W:0]  ld, rd;
  logic [DIGIT_W-1:0] half;
  logic              gap;
  logic              final_lvl;
  logic              last;

  always_comb begin
    cnt_eff   = s1_item.start_req ? '0 : cnt_r;
    fin_eff   = s1_item.start_req ? 1'b0 : fin_r;
    produce   = !fin_eff;
    ld        = {1'b0, s1_item.left_present ? s1_item.left_digit : '0};
    rd        = {1'b0, s1_item.right_present ? s1_item.right_digit : DIGIT_TOP};
    gap       = rd > (ld + 1'b1);
    half      = DIGIT_W'((rd - ld) >> 1);
    final_lvl = (cnt_eff == CNT_W'(MAX_LEVELS - 1));
    last      = gap || final_lvl;

    res_item.level   = to_level(cnt_eff);
    res_item.is_last = last;
    if (gap) begin
      res_item.out_digit = ld[DIGIT_W-1:0] + half;
      res_item.out_actor = s1_item.new_actor;
    end else if (final_lvl) begin
      // saturate at the top digit
      res_item.out_digit = (ld[DIGIT_W-1:0] == DIGIT_TOP) ? DIGIT_TOP
                                                          : ld[DIGIT_W-1:0] + 1'b1;
      res_item.out_actor = s1_item.new_actor;
    end else begin
      res_item.out_digit = ld[DIGIT_W-1:0];
      res_item.out_actor = s1_item.left_present ? s1_item.left_actor : '0;
    end
  end

  // drop idle items at once; hold a producing item until the result slot frees
  assign s1_take  = s1_valid && (!produce || slot_free);
  assign res_load = s1_valid && produce && slot_free;

  always_comb begin
    cnt_nxt = cnt_r;
    fin_nxt = fin_r;
    if (s1_take) begin
      cnt_nxt = cnt_eff;
      fin_nxt = fin_eff;
      if (produce) begin
        if (last) begin
          cnt_nxt = '0;
          fin_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_eff + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fin_r <= 1'b1;
    end else begin
      cnt_r <= cnt_nxt;
      fin_r <= fin_nxt;
    end
  end
endmodule

// ----- design/crdt_position_between.sv -----
// Logoot position allocator: each transfer on in_ch carries one level of a
// left/right position pair, level zero flagged by start_req, and yields one
// component of a new position sorting between them on out_ch; idle levels
// (no pair in progress and no start_req) produce nothing. One level is taken
// every cycle while out_ch is not stalled; a level passes the input register and
// then the result register, with the gap compare, halving add and saturating
// increment between them. A stalled result holds in the result register and
// the next producing level holds in the input register; in_ch.ready then
// follows out_ch.ready in the same cycle, so a further level enters only as
// the waiting result leaves.
module crdt_position_between (
  input  logic      clk,
  input  logic      rst_n,
  cpb_in_if.sink    in_ch,
  cpb_out_if.source out_ch
);
  import cpb_pkg::*;

  in_item_t  in_item, s1_item;
  out_item_t res_item, out_r;
  logic      s1_valid, s1_take, res_load, slot_free;
  logic      out_valid_r, out_valid_nxt;

  assign in_item.start_req     = in_ch.start_req;
  assign in_item.left_present  = in_ch.left_present;
  assign in_item.left_digit    = in_ch.left_digit;
  assign in_item.left_actor    = in_ch.left_actor;
  assign in_item.right_present = in_ch.right_present;
  assign in_item.right_digit   = in_ch.right_digit;
  assign in_item.new_actor     = in_ch.new_actor;

  cpb_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  cpb_alloc u_alloc (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .slot_free (slot_free),
    .s1_take   (s1_take),
    .res_load  (res_load),
    .res_item  (res_item)
  );

  assign slot_free     = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = slot_free ? res_load : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res_item;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_digit = out_r.out_digit;
  assign out_ch.out_actor = out_r.out_actor;
  assign out_ch.level     = out_r.level;
  assign out_ch.is_last   = out_r.is_last;
endmodule

// ----- design/cpb_checker.sv -----
module cpb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cpb_pkg::DIGIT_W-1:0] out_digit,
  input logic [cpb_pkg::LEVEL_W-1:0] level,
  input logic                        is_last
);
  import cpb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit) && $stable(level))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (MAX_LEVELS < 8) |-> int'(level) < MAX_LEVELS)
    else $error("level beyond depth");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (MAX_LEVELS <= 8) && int'(level) == MAX_LEVELS - 1 |-> is_last)
    else $error("deepest level not marked last");
endmodule

bind crdt_position_between cpb_checker u_cpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_digit (out_ch.out_digit),
  .level     (out_ch.level),
  .is_last   (out_ch.is_last)
);

// ----- tb/cpb_alloc_checker.sv -----
`timescale 1ns / 100ps

module cpb_alloc_checker
  import cpb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  cpb_in_if    in_mon,
  cpb_out_if   out_mon,
  output int   n_fail,
  output int   n_pending
);

  out_item_t pending_components[$];
  int        depth;
  bit        waiting;

  // Return 1 and the component when this level produces one.
  function automatic bit next_component(input in_item_t it, output out_item_t res);
    logic [DIGIT_W:0] ld;
    logic [DIGIT_W:0] rd;
    bit               last;
    res = '0;
    if (it.start_req) begin
      depth   = 0;
      waiting = 1'b0;
    end
    if (waiting) return 1'b0;
    ld = it.left_present  ? {1'b0, it.left_digit}  : '0;
    rd = it.right_present ? {1'b0, it.right_digit} : {1'b0, DIGIT_TOP};
    if (rd > ld + 1'b1) begin
      res.out_digit = DIGIT_W'(ld + ((rd - ld) >> 1));
      res.out_actor = it.new_actor;
      last = 1'b1;
    end else if (depth + 1 >= MAX_LEVELS) begin
      // final level: step past left, saturating
      res.out_digit = (ld[DIGIT_W-1:0] == DIGIT_TOP) ? DIGIT_TOP : ld[DIGIT_W-1:0] + 1'b1;
      res.out_actor = it.new_actor;
      last = 1'b1;
    end else begin
      res.out_digit = ld[DIGIT_W-1:0];
      res.out_actor = it.left_present ? it.left_actor : '0;
      last = 1'b0;
    end
    res.level   = LEVEL_W'(depth);
    res.is_last = last;
    if (last) begin
      waiting = 1'b1;
      depth   = 0;
    end else begin
      depth++;
    end
    return 1'b1;
  endfunction

  initial begin
    n_fail    = 0;
    n_pending = 0;
    depth     = 0;
    waiting   = 1'b1;
  end

  always @(posedge clk) begin
    in_item_t  it;
    out_item_t exp_c;
    out_item_t got;
    if (rst_n) begin
      // check the result side first: it can only belong to an older level
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.out_digit, out_mon.out_actor, out_mon.level, out_mon.is_last};
        if (pending_components.size() == 0) begin
          $error("unexpected result transfer: digit %h actor %h level %0d last %0b",
                 got.out_digit, got.out_actor, got.level, got.is_last);
          n_fail++;
        end else begin
          exp_c = pending_components.pop_front();
          if (got.out_digit !== exp_c.out_digit) begin
            $error("out_digit mismatch: expected %h, got %h", exp_c.out_digit, got.out_digit);
            n_fail++;
          end
          if (got.out_actor !== exp_c.out_actor) begin
            $error("out_actor mismatch: expected %h, got %h", exp_c.out_actor, got.out_actor);
            n_fail++;
          end
          if (got.level !== exp_c.level) begin
            $error("level mismatch: expected %0d, got %0d", exp_c.level, got.level);
            n_fail++;
          end
          if (got.is_last !== exp_c.is_last) begin
            $error("is_last mismatch: expected %0b, got %0b", exp_c.is_last, got.is_last);
            n_fail++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it = {in_mon.start_req, in_mon.left_present, in_mon.left_digit, in_mon.left_actor,
              in_mon.right_present, in_mon.right_digit, in_mon.new_actor};
        if (next_component(it, exp_c)) pending_components.push_back(exp_c);
      end
    end
    n_pending = pending_components.size();
  end

endmodule

// ----- tb/tb_crdt_position_between.sv -----
`timescale 1ns / 100ps

module tb_crdt_position_between;
  import cpb_pkg::*;

  localparam int N_ITEMS     = 1950;
  localparam int N_PHASES    = 4;
  localparam int SND_IDLE[4] = '{0, 54, 0, 14};
  localparam int RCV_STALL[4] = '{0, 0, 54, 14};

  logic clk;
  logic rst_n;
  int   fail_cnt;
  int   pend_cnt;
  int   snd_idle;
  int   rcv_stall;
  int   sent;

  cpb_in_if  in_ch ();
  cpb_out_if out_ch ();

  crdt_position_between u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cpb_alloc_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .n_fail    (fail_cnt),
    .n_pending (pend_cnt)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= rcv_stall);
  end

  function automatic in_item_t mk(bit s, bit lp, logic [15:0] ld, logic [31:0] la,
                                  bit rp, logic [15:0] rd, logic [31:0] na);
    in_item_t it;
    it = {s, lp, ld, la, rp, rd, na};
    return it;
  endfunction

  function automatic in_item_t noise_level();
    in_item_t it;
    it.start_req     = ($urandom_range(0, 3) == 0);
    it.left_present  = 1'($urandom_range(0, 1));
    it.left_digit    = 16'($urandom);
    it.left_actor    = $urandom;
    it.right_present = 1'($urandom_range(0, 1));
    it.right_digit   = 16'($urandom);
    it.new_actor     = $urandom;
    return it;
  endfunction

  // A level with no room between left and right.
  function automatic in_item_t tight_level(bit s);
    in_item_t it;
    it = noise_level();
    it.start_req     = s;
    it.left_present  = 1'b1;
    it.right_present = 1'b1;
    case ($urandom_range(0, 4))
      0: it.right_digit = it.left_digit;
      1: it.right_digit = (it.left_digit == DIGIT_TOP) ? DIGIT_TOP : it.left_digit + 1'b1;
      2: it.right_digit = 16'($urandom_range(0, it.left_digit));
      3: begin
        it.left_present = 1'b0;
        it.right_digit  = 16'($urandom_range(0, 1));
      end
      default: begin
        it.left_digit    = 16'($urandom_range(16'hFFFE, 16'hFFFF));
        it.right_present = 1'b0;
      end
    endcase
    return it;
  endfunction

  // A level where right exceeds left by at least two.
  function automatic in_item_t gap_level(bit s);
    in_item_t    it;
    int unsigned ld;
    it = noise_level();
    it.start_req = s;
    if (it.left_present) it.left_digit = 16'($urandom_range(0, 16'hFFFD));
    ld = it.left_present ? it.left_digit : 0;
    if (it.right_present) begin
      if ($urandom_range(0, 3) == 0) it.right_digit = 16'(ld + 2);
      else it.right_digit = 16'($urandom_range(ld + 2, 16'hFFFF));
    end
    return it;
  endfunction

  // Enter at a falling edge; leave at the falling edge after the transfer.
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    {in_ch.start_req, in_ch.left_present, in_ch.left_digit, in_ch.left_actor,
     in_ch.right_present, in_ch.right_digit, in_ch.new_actor} = it;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_pair();
    int tight_n;
    int stop_at;
    // tight_n of MAX_LEVELS reaches the final-level fallback
    tight_n = $urandom_range(0, MAX_LEVELS);
    stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_LEVELS - 1) : MAX_LEVELS;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      if (l == stop_at) break;
      if (l < tight_n) begin
        send_item(tight_level(l == 0));
      end else begin
        send_item(gap_level(l == 0));
        break;
      end
    end
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (pend_cnt != 0) @(negedge clk);
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    sent          = 0;
    snd_idle      = 0;
    rcv_stall     = 0;
    in_ch.valid   = 1'b0;
    {in_ch.start_req, in_ch.left_present, in_ch.left_digit, in_ch.left_actor,
     in_ch.right_present, in_ch.right_digit, in_ch.new_actor} = '0;
    out_ch.ready  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle level before any start: dropped
    send_item(mk(0, 1, 16'h1234, 32'hDEAD_BEEF, 1, 16'h2000, 32'h1));
    send_item(mk(1, 1, 16'h0000, 32'h0, 1, 16'hFFFF, 32'hFFFF_FFFF));
    send_item(mk(1, 0, 16'hFFFF, 32'hFFFF_FFFF, 0, 16'h0000, 32'h0));
    // top digit all the way down: last level saturates
    for (int l = 0; l < MAX_LEVELS; l++)
      send_item(mk(l == 0, 1, 16'hFFFF, 32'hFFFF_FFFF - l, 0, 16'h0, 32'hA5A5_5A5A));
    send_item(mk(0, 1, 16'h0001, 32'h1, 1, 16'h0100, 32'h2));
    // restart in the middle of a pair
    send_item(mk(1, 1, 16'h0005, 32'h11, 1, 16'h0006, 32'h22));
    send_item(mk(1, 1, 16'h0005, 32'h33, 1, 16'h0007, 32'h44));
    // inverted pair copies left, then left absent with tight right
    send_item(mk(1, 1, 16'h0009, 32'h55, 1, 16'h0003, 32'h66));
    send_item(mk(0, 0, 16'hBEEF, 32'h77, 1, 16'h0001, 32'h88));
    send_item(mk(0, 1, 16'd40000, 32'h99, 0, 16'hFFFF, 32'hAA));
    // no gap anywhere: last level steps past left
    for (int l = 0; l < MAX_LEVELS; l++)
      send_item(mk(l == 0, 1, 16'd100, l, 1, 16'd100, 32'h0));
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      snd_idle  = SND_IDLE[p];
      rcv_stall = RCV_STALL[p];
      while (sent < 25 + (p + 1) * N_ITEMS / N_PHASES) begin
        if ($urandom_range(0, 6) == 0) send_item(noise_level());
        else send_pair();
      end
      // hold the sender until every result has come back
      drain();
    end

    rcv_stall = 0;
    repeat (16) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("** crdt_position_between: PASSED **");
    end else begin
      $display("** crdt_position_between: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** crdt_position_between: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
design/cpb_pkg.sv
design/cpb_if.sv
design/cpb_in_reg.sv
design/cpb_alloc.sv
design/crdt_position_between.sv
design/cpb_checker.sv
tb/cpb_alloc_checker.sv
tb/tb_crdt_position_between.sv
